// File: sv/lfu_pr_pkg.sv
// Shared constants for the LFU page replacement core.
// No dependencies; used by lfu_page_replacement_core.
package lfu_pr_pkg;

    localparam int PAGE_COUNT_DEF  = 256;  // default number of virtual pages
    localparam int FRAME_COUNT_DEF = 16;   // default number of physical frames

    localparam int PAGE_IN_W  = 8;         // page_number field width
    localparam int CFG_W      = 5;         // frames_in_use register width
    localparam int CFG_RESET  = 16;        // frames_in_use after reset
    localparam int COUNT_W    = 16;        // per-frame access count
    localparam int TIME_W     = 32;        // access clock / last-use stamp
    localparam int TOTAL_W    = 32;        // fault total
    localparam int M_FIELDS_W = 1 + 1 + PAGE_IN_W + TOTAL_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

endpackage

// File: sv/lfu_page_replacement_core.sv
// LFU page replacement core with oldest-access tie-break; uses lfu_pr_pkg and lfu_pr_ram.
// A reference passes a modulo reduction when PAGE_COUNT < 256, then a one-frame-per-cycle
// scan of the frame RAM through its single read port, then the update. One reference in
// flight at a time: no new input beat is taken until the result beat is written; the
// update also waits while the previous result beat is held.
// Reset (aresetn, sync, active low) empties all frames, zeroes clock and faults, limit 16.
module lfu_page_replacement_core #(
    parameter int PAGE_COUNT  = lfu_pr_pkg::PAGE_COUNT_DEF,
    parameter int FRAME_COUNT = lfu_pr_pkg::FRAME_COUNT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write channel: frames_in_use
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lfu_pr_pkg::CFG_W-1:0]      cfg_data,
    // input beats
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lfu_pr_pkg::PAGE_IN_W-1:0]  s_tdata,   // [7:0] page_number
    // result beats
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] page_fault, [1] evict_valid, [9:2] evicted_page, [41:10] fault_total,
    // [47:42] zero
    output logic [lfu_pr_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int PAGE_W  = $clog2(PAGE_COUNT);
    localparam int IDX_W   = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int FILL_W  = $clog2(FRAME_COUNT + 1);
    localparam int COUNT_W = lfu_pr_pkg::COUNT_W;
    localparam int TIME_W  = lfu_pr_pkg::TIME_W;
    localparam int TOTAL_W = lfu_pr_pkg::TOTAL_W;
    localparam int IN_W    = lfu_pr_pkg::PAGE_IN_W;
    localparam int ENTRY_W = PAGE_W + COUNT_W + TIME_W;
    localparam int PAD_W   = lfu_pr_pkg::M_DATA_W - lfu_pr_pkg::M_FIELDS_W;
    // page numbers above the page space need folding back into it
    localparam bit NEED_RED = (PAGE_COUNT < (1 << IN_W));

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_REDUCE = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0]  state_reg, state_next;

    // configuration
    logic [lfu_pr_pkg::CFG_W-1:0] cfg_reg;
    logic [FILL_W-1:0]            limit;

    // global counters
    logic [FILL_W-1:0]  filled_reg, filled_next;
    logic [TIME_W-1:0]  clock_reg, clock_next;
    logic [TOTAL_W-1:0] faults_reg, faults_next;

    // current reference
    logic [IN_W-1:0]    red_reg, red_next;
    logic [2:0]         red_k_reg, red_k_next;
    logic [15:0]        red_sub;
    logic [PAGE_W-1:0]  page_cur;

    // scan: read issue and compare stage
    logic [FILL_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;

    logic               found_reg, found_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [COUNT_W-1:0] hit_count_reg, hit_count_next;

    logic               best_valid_reg, best_valid_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [COUNT_W-1:0] best_count_reg, best_count_next;
    logic [TIME_W-1:0]  best_time_reg, best_time_next;
    logic [PAGE_W-1:0]  best_page_reg, best_page_next;

    // frame RAM
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [PAGE_W-1:0]  rd_page;
    logic [COUNT_W-1:0] rd_count;
    logic [TIME_W-1:0]  rd_time;
    logic               rd_better;

    // update values
    logic [COUNT_W-1:0] wr_count;
    logic               evict;
    logic [PAGE_W-1:0]  ev_page;

    // result register
    logic                            m_valid_reg, m_valid_next;
    logic [lfu_pr_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    lfu_pr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FRAME_COUNT),
        .AW    (IDX_W)
    ) u_frames (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // effective frame limit: 0 acts as 1, above FRAME_COUNT clamps
    always_comb begin
        if (cfg_reg == '0) begin
            limit = FILL_W'(1);
        end else if (int'(cfg_reg) > FRAME_COUNT) begin
            limit = FILL_W'(FRAME_COUNT);
        end else begin
            limit = FILL_W'(cfg_reg);
        end
    end

    assign page_cur = PAGE_W'(red_reg);
    assign red_sub  = 16'(PAGE_COUNT) << red_k_reg;

    assign rd_page  = ram_rdata[PAGE_W-1:0];
    assign rd_count = ram_rdata[PAGE_W +: COUNT_W];
    assign rd_time  = ram_rdata[PAGE_W+COUNT_W +: TIME_W];

    // lowest count wins; equal counts go to the older stamp; full ties keep lower index
    assign rd_better = !best_valid_reg || (rd_count < best_count_reg) ||
                       ((rd_count == best_count_reg) && (rd_time < best_time_reg));

    always_comb begin
        state_next      = state_reg;
        filled_next     = filled_reg;
        clock_next      = clock_reg;
        faults_next     = faults_reg;
        red_next        = red_reg;
        red_k_next      = red_k_reg;
        rd_cnt_next     = rd_cnt_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = rd_cnt_reg[IDX_W-1:0];
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_count_next  = hit_count_reg;
        best_valid_next = best_valid_reg;
        best_idx_next   = best_idx_reg;
        best_count_next = best_count_reg;
        best_time_next  = best_time_reg;
        best_page_next  = best_page_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = hit_idx_reg;
        wr_count        = COUNT_W'(1);
        evict           = 1'b0;
        ev_page         = '0;

        // compare stage: one frame per cycle
        if (cmp_valid_reg) begin
            if (rd_page == page_cur) begin
                found_next     = 1'b1;
                hit_idx_next   = cmp_idx_reg;
                hit_count_next = rd_count;
            end
            if (rd_better) begin
                best_valid_next = 1'b1;
                best_idx_next   = cmp_idx_reg;
                best_count_next = rd_count;
                best_time_next  = rd_time;
                best_page_next  = rd_page;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    red_next        = s_tdata;
                    red_k_next      = 3'd7;
                    rd_cnt_next     = '0;
                    found_next      = 1'b0;
                    best_valid_next = 1'b0;
                    if (clock_reg != '1) begin
                        clock_next = clock_reg + TIME_W'(1);
                    end
                    state_next = NEED_RED ? ST_REDUCE : ST_SCAN;
                end
            end
            ST_REDUCE: begin
                // restoring remainder, one shifted subtrahend per cycle
                if ({8'd0, red_reg} >= red_sub) begin
                    red_next = red_reg - red_sub[IN_W-1:0];
                end
                red_k_next = red_k_reg - 3'd1;
                if (red_k_reg == 3'd0) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_cnt_reg < filled_reg) begin
                    cmp_valid_next = 1'b1;
                    rd_cnt_next    = rd_cnt_reg + FILL_W'(1);
                end else if (!cmp_valid_reg) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (!m_valid_reg || m_tready) begin
                    ram_we = 1'b1;
                    if (found_reg) begin
                        ram_waddr = hit_idx_reg;
                        wr_count  = (hit_count_reg == '1) ? hit_count_reg
                                                          : hit_count_reg + COUNT_W'(1);
                    end else begin
                        if (filled_reg < limit) begin
                            ram_waddr   = filled_reg[IDX_W-1:0];
                            filled_next = filled_reg + FILL_W'(1);
                        end else begin
                            ram_waddr = best_idx_reg;
                            evict     = 1'b1;
                            ev_page   = best_page_reg;
                        end
                        if (faults_reg != '1) begin
                            faults_next = faults_reg + TOTAL_W'(1);
                        end
                    end
                    m_valid_next = 1'b1;
                    m_data_next  = {PAD_W'(0), faults_next, IN_W'(ev_page), evict, !found_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ram_wdata = {clock_reg, wr_count, page_cur};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cfg_reg        <= lfu_pr_pkg::CFG_W'(lfu_pr_pkg::CFG_RESET);
            filled_reg     <= '0;
            clock_reg      <= '0;
            faults_reg     <= '0;
            rd_cnt_reg     <= '0;
            cmp_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            best_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            if (cfg_valid) begin
                cfg_reg <= cfg_data;
            end
            filled_reg     <= filled_next;
            clock_reg      <= clock_next;
            faults_reg     <= faults_next;
            rd_cnt_reg     <= rd_cnt_next;
            cmp_valid_reg  <= cmp_valid_next;
            found_reg      <= found_next;
            best_valid_reg <= best_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        red_reg        <= red_next;
        red_k_reg      <= red_k_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_count_reg  <= hit_count_next;
        best_idx_reg   <= best_idx_next;
        best_count_reg <= best_count_next;
        best_time_reg  <= best_time_next;
        best_page_reg  <= best_page_next;
        m_data_reg     <= m_data_next;
    end

endmodule

// File: sv/lfu_pr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfu_pr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: tb/sv/lfu_page_replacement_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for lfu_page_replacement_core: page reference beats in,
// hit/fault/eviction beats out, compared against an in-bench LFU predictor.
// Depends on lfu_pr_pkg and the core (with its frame RAM).
module lfu_page_replacement_core_test;

    localparam int PAGE_IN_W     = lfu_pr_pkg::PAGE_IN_W;
    localparam int CFG_W         = lfu_pr_pkg::CFG_W;
    localparam int CFG_RESET     = lfu_pr_pkg::CFG_RESET;
    localparam int COUNT_W       = lfu_pr_pkg::COUNT_W;
    localparam int TIME_W        = lfu_pr_pkg::TIME_W;
    localparam int TOTAL_W       = lfu_pr_pkg::TOTAL_W;
    localparam int M_DATA_W      = lfu_pr_pkg::M_DATA_W;
    localparam int NFRAMES       = lfu_pr_pkg::FRAME_COUNT_DEF;
    localparam int NPAGES        = lfu_pr_pkg::PAGE_COUNT_DEF;
    localparam int SETTLE_CYCLES = 40;       // longer than the worst-case reference through the core
    localparam int CYCLE_LIMIT   = 1000000;  // a full run under worst stalls is well below
    localparam int HOLD_CYCLES   = 400;      // long receiver hold-off
    localparam int HAMMER_HITS   = 40;       // back-to-back hits on one frame

    // one result beat
    typedef struct packed {
        logic                 fault;
        logic                 evict;
        logic [PAGE_IN_W-1:0] victim;
        logic [TOTAL_W-1:0]   total;
    } page_outcome_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [PAGE_IN_W-1:0] s_tdata   = '0;  // [7:0] page_number
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // [0] page_fault, [1] evict_valid, [9:2] evicted_page, [41:10] fault_total
    logic [M_DATA_W-1:0]  m_tdata;

    lfu_page_replacement_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor state: mirrors the core's frame table and counters.
    // ------------------------------------------------------------------
    bit                   resident [NPAGES];
    logic [PAGE_IN_W-1:0] fr_page  [NFRAMES];
    logic [COUNT_W-1:0]   fr_hits  [NFRAMES];
    logic [TIME_W-1:0]    fr_stamp [NFRAMES];
    int                   filled     = 0;
    logic [TIME_W-1:0]    tick       = '0;
    logic [TOTAL_W-1:0]   faults     = '0;
    logic [CFG_W-1:0]     frames_cfg = CFG_W'(CFG_RESET);

    page_outcome_t outcome_due[$];   // expected result beats, oldest first
    int            fail_count  = 0;
    int unsigned   cycle_count = 0;

    // pacing controls
    bit tx_steady       = 1'b0;      // sender offers back to back
    bit rx_steady       = 1'b0;      // receiver always ready
    bit rx_hold         = 1'b0;      // receiver held off by the long-hold process
    int hold_cycles_req = 0;
    int burst_left      = 0;

    // least count wins, equal counts go to the older stamp, then the lower frame
    function automatic int pick_victim();
        int best;
        int k;
        best = 0;
        for (k = 1; k < filled; k++) begin
            if (fr_hits[k] < fr_hits[best] ||
                (fr_hits[k] == fr_hits[best] && fr_stamp[k] < fr_stamp[best]))
                best = k;
        end
        return best;
    endfunction

    // applies one reference to the predictor and returns the expected beat
    function automatic page_outcome_t lookup_page(input logic [PAGE_IN_W-1:0] pg);
        page_outcome_t r;
        int            k;
        int            slot;
        int            lim;
        r = '0;
        if (tick != '1) tick++;
        if (resident[pg]) begin
            for (k = 0; k < filled; k++) begin
                if (fr_page[k] == pg) begin
                    if (fr_hits[k] != '1) fr_hits[k]++;
                    fr_stamp[k] = tick;
                end
            end
        end else begin
            r.fault = 1'b1;
            // zero acts as one frame, anything above the frame count as all frames
            lim = (frames_cfg == 0) ? 1 : ((frames_cfg > NFRAMES) ? NFRAMES : frames_cfg);
            if (filled < lim) begin
                slot = filled;
                filled++;
            end else begin
                // limit may be below the fill level: no frame is freed, just evict
                slot = pick_victim();
                r.evict  = 1'b1;
                r.victim = fr_page[slot];
                resident[fr_page[slot]] = 1'b0;
            end
            fr_page[slot]  = pg;
            fr_hits[slot]  = COUNT_W'(1);
            fr_stamp[slot] = tick;
            resident[pg]   = 1'b1;
            if (faults != '1) faults++;
        end
        r.total = faults;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got 0x%0h expected 0x%0h at cycle %0d",
                 what, got, want, cycle_count);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Result checker: every accepted result beat against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        page_outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (outcome_due.size() == 0) begin
                report_mismatch("unexpected result beat", m_tdata[31:0], '0);
            end else begin
                want = outcome_due.pop_front();
                if (m_tdata[0] !== want.fault)
                    report_mismatch("page_fault", 32'(m_tdata[0]), 32'(want.fault));
                if (m_tdata[1] !== want.evict)
                    report_mismatch("evict_valid", 32'(m_tdata[1]), 32'(want.evict));
                if (m_tdata[9:2] !== want.victim)
                    report_mismatch("evicted_page", 32'(m_tdata[9:2]), 32'(want.victim));
                if (m_tdata[41:10] !== want.total)
                    report_mismatch("fault_total", m_tdata[41:10], want.total);
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL lfu_page_replacement_core");
            $finish;
        end
    end

    // Long receiver hold-off, counted here so the sender keeps offering meanwhile.
    initial begin : long_hold
        int n;
        forever begin
            @(posedge aclk);
            if (hold_cycles_req != 0) begin
                n = hold_cycles_req;
                hold_cycles_req = 0;
                rx_hold <= 1'b1;
                repeat (n) @(posedge aclk);
                rx_hold <= 1'b0;
            end
        end
    end

    // Receiver: rotating stall pattern, reloaded at random intervals.
    // Some reloads are all-ready so there are stretches without stalls.
    initial begin : receiver
        logic [15:0] pat;
        int          left;
        pat  = '1;
        left = 0;
        forever begin
            @(posedge aclk);
            if (left == 0) begin
                case ($urandom_range(3))
                    0: pat = '1;
                    1: pat = 16'($urandom);
                    2: pat = 16'($urandom | $urandom);
                    default: pat = 16'(($urandom & $urandom) | 32'h0001);
                endcase
                left = $urandom_range(16, 96);
            end
            left--;
            pat = {pat[14:0], pat[15]};
            m_tready <= rx_steady || (!rx_hold && pat[0]);
        end
    end

    // ------------------------------------------------------------------
    // Sender side. All tasks start and end right after a rising edge.
    // ------------------------------------------------------------------
    task automatic send_page(input logic [PAGE_IN_W-1:0] pg);
        s_tvalid <= 1'b1;
        s_tdata  <= pg;
        do @(posedge aclk); while (!s_tready);
        outcome_due = {outcome_due, lookup_page(pg)};
    endtask

    task automatic idle_sender(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // bursts of random length with random gaps between them
    task automatic send_paced(input logic [PAGE_IN_W-1:0] pg);
        send_page(pg);
        if (!tx_steady) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(15);
                idle_sender($urandom_range(1, 8));
            end
        end
    endtask

    // sender pauses until every expected beat is back and the core is idle
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (outcome_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_frame_limit(input logic [CFG_W-1:0] v);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        frames_cfg = v;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // limit of zero behaves as a single frame; page extremes
    task automatic test_limit_floor();
        set_frame_limit('0);
        send_paced(8'h00);
        send_paced(8'h00);
        send_paced(8'hFF);   // evicts 0x00
        send_paced(8'hFF);
        send_paced(8'h00);   // evicts 0xFF
    endtask

    // one frame hit back to back many times, then evicted
    task automatic test_single_frame_hammer();
        int i;
        set_frame_limit(5'd1);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        send_page(8'h5A);
        for (i = 0; i < HAMMER_HITS; i++)
            send_page(8'h5A);
        send_page(8'hA5);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // limit above the frame count acts as all frames; fill up, then tie-break evictions
    task automatic test_fill_directed();
        logic [PAGE_IN_W-1:0] walk [$];
        walk = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
                 8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F};
        set_frame_limit(5'd31);
        foreach (walk[i]) send_paced(walk[i]);
        send_paced(8'h01);   // hit
        send_paced(8'h55);   // all count-one frames tie: oldest goes
        send_paced(8'hAA);
        send_paced(8'h55);
    endtask

    // limit dropped below the fill level: misses still evict among all frames
    task automatic test_lower_limit();
        int i;
        set_frame_limit(5'd3);
        for (i = 0; i < 8; i++)
            send_paced(8'hC0 + i[7:0]);
        send_paced(8'hC1);
        send_paced(8'h33);
    endtask

    // receiver holds off long while the sender keeps offering: core backs up
    task automatic test_long_hold();
        int i;
        settle_block();
        hold_cycles_req = HOLD_CYCLES;
        tx_steady = 1'b1;
        for (i = 0; i < 20; i++)
            send_page(PAGE_IN_W'($urandom_range(NPAGES - 1)));
        tx_steady = 1'b0;
        settle_block();
    endtask

    // random references under one limit, mostly from a small working set
    task automatic test_random_phase(input logic [CFG_W-1:0] lim, input int n);
        logic [PAGE_IN_W-1:0] pool [$];
        int                   i;
        int                   sz;
        set_frame_limit(lim);
        sz = ((lim == 0) ? 1 : ((lim > NFRAMES) ? NFRAMES : lim)) + 4;
        for (i = 0; i < sz; i++)
            pool = {pool, PAGE_IN_W'($urandom_range(NPAGES - 1))};
        for (i = 0; i < n; i++) begin
            if ($urandom_range(15) == 0)
                pool[$urandom_range(sz - 1)] = PAGE_IN_W'($urandom_range(NPAGES - 1));
            if ($urandom_range(3) != 0)
                send_paced(pool[$urandom_range(sz - 1)]);
            else
                send_paced(PAGE_IN_W'($urandom_range(NPAGES - 1)));
        end
    endtask

    initial begin : main
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_limit_floor();
        test_single_frame_hammer();
        test_random_phase(5'd4, 100);
        test_random_phase(5'd9, 100);
        test_fill_directed();
        test_lower_limit();
        test_long_hold();
        test_random_phase(5'd16, 150);
        test_random_phase(5'd2, 100);

        settle_block();
        if (outcome_due.size() != 0)
            report_mismatch("results never delivered", outcome_due.size(), 0);
        if (fail_count == 0) begin
            $display("PASS lfu_page_replacement_core");
        end else begin
            $display("FAIL lfu_page_replacement_core");
        end
        $finish;
    end

endmodule

// File: files.f
sv/lfu_pr_pkg.sv
sv/lfu_pr_ram.sv
sv/lfu_page_replacement_core.sv
tb/sv/lfu_page_replacement_core_test.sv
